// ----- sv/hrbp_pkg.sv -----
// Shared types, character codes and character-class functions for the
// HTTP response byte parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrbp_pkg;

    // Verdict codes.
    localparam logic [1:0] VERDICT_MORE = 2'd0;
    localparam logic [1:0] VERDICT_DONE = 2'd1;
    localparam logic [1:0] VERDICT_BAD  = 2'd2;

    // Byte role codes.
    localparam logic [1:0] ROLE_FRAME   = 2'd0;
    localparam logic [1:0] ROLE_NAME    = 2'd1;
    localparam logic [1:0] ROLE_VALUE   = 2'd2;
    localparam logic [1:0] ROLE_CONTENT = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Length of "content-length" and the ceiling of the match position.
    localparam logic [3:0] NAME_LEN      = 4'd14;
    localparam logic [3:0] MATCH_POS_MAX = 4'd15;

    // One result word as it leaves the parser core.
    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  byte_role;
        logic        new_header;
        logic [7:0]  echo_byte;
        logic [15:0] status_code;
        logic [31:0] body_length;
    } hrbp_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_text(input logic [7:0] c);
        return (c >= 8'd32) && (c < 8'd127);
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        logic hit;
        unique case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
            8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
            8'h09: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return is_text(c) && !is_special(c);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
    endfunction

    // Lower-case "content-length", one character per match position.
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h63;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h6C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hrbp_channels.sv -----
// Valid/ready channel interfaces for the byte stream and the result stream.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface hrbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface hrbp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [1:0]  byte_role;
    logic        new_header;
    logic [7:0]  echo_byte;
    logic [15:0] status_code;
    logic [31:0] body_length;

    modport source (output valid, output verdict, output byte_role, output new_header,
                    output echo_byte, output status_code, output body_length,
                    input ready);
    modport sink   (input valid, input verdict, input byte_role, input new_header,
                    input echo_byte, input status_code, input body_length,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/hrbp_core.sv -----
// Parser state and the per-byte transition: grammar phase, status and
// Content-Length accumulation, header name matching. Uses hrbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrbp_core
    import hrbp_pkg::*;
#(
    parameter int LENGTH_BITS = 32,
    parameter int STATUS_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   data_byte,
    input  wire logic         restart,
    output hrbp_result_t      result
);

    typedef enum logic [4:0] {
        PH_H, PH_T1, PH_T2, PH_P, PH_SLASH, PH_MAJ0, PH_MAJ, PH_MIN0, PH_MIN,
        PH_ST0, PH_ST, PH_TEXT, PH_TEXT_LF, PH_LINE, PH_NAME, PH_COLON_SP,
        PH_CONT, PH_VALUE, PH_HDR_LF, PH_BLANK_LF, PH_CONTENT, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        VS_LEAD, VS_DIGITS, VS_STOP
    } value_stage_t;

    // State registers.
    phase_t                 phase_reg, phase_next, cur_phase;
    logic [STATUS_BITS-1:0] status_reg, status_next, cur_status;
    logic [LENGTH_BITS-1:0] accum_reg, accum_next, cur_accum;
    logic [LENGTH_BITS-1:0] length_value_reg, length_value_next, cur_length_value;
    logic [LENGTH_BITS-1:0] count_reg, count_next, cur_count;
    logic                   has_digits_reg, has_digits_next, cur_has_digits;
    logic [3:0]             match_pos_reg, match_pos_next, cur_match_pos;
    logic                   matches_reg, matches_next, cur_matches;
    logic                   in_length_reg, in_length_next, cur_in_length;
    logic                   any_header_reg, any_header_next, cur_any_header;
    value_stage_t           stage_reg, stage_next, cur_stage;
    logic                   negative_reg, negative_next, cur_negative;
    logic                   overflow_reg, overflow_next, cur_overflow;
    logic                   length_bad_reg, length_bad_next, cur_length_bad;

    // Per-byte working signals.
    logic [STATUS_BITS+3:0] status_prod;
    logic [LENGTH_BITS+3:0] length_prod;
    logic                   status_ovf;
    logic                   length_ovf;
    logic [LENGTH_BITS-1:0] fin_length_value;
    logic                   fin_bad;
    logic [LENGTH_BITS-1:0] count_inc;
    logic                   bad;
    logic                   feed_digits;
    logic [1:0]             verdict;
    logic [1:0]             role;
    logic                   new_hdr;

    // Restart takes the state back to reset before this byte is handled.
    assign cur_phase        = restart ? PH_H    : phase_reg;
    assign cur_status       = restart ? '0      : status_reg;
    assign cur_accum        = restart ? '0      : accum_reg;
    assign cur_length_value = restart ? '0      : length_value_reg;
    assign cur_count        = restart ? '0      : count_reg;
    assign cur_has_digits   = restart ? 1'b0    : has_digits_reg;
    assign cur_match_pos    = restart ? 4'd0    : match_pos_reg;
    assign cur_matches      = restart ? 1'b0    : matches_reg;
    assign cur_in_length    = restart ? 1'b0    : in_length_reg;
    assign cur_any_header   = restart ? 1'b0    : any_header_reg;
    assign cur_stage        = restart ? VS_LEAD : stage_reg;
    assign cur_negative     = restart ? 1'b0    : negative_reg;
    assign cur_overflow     = restart ? 1'b0    : overflow_reg;
    assign cur_length_bad   = restart ? 1'b0    : length_bad_reg;

    // Decimal accumulate by ten plus the digit; any carry into the top four
    // bits means the value no longer fits.
    assign status_prod = ({4'b0, cur_status} << 3) + ({4'b0, cur_status} << 1)
                       + (STATUS_BITS+4)'(data_byte[3:0]);
    assign length_prod = ({4'b0, cur_accum} << 3) + ({4'b0, cur_accum} << 1)
                       + (LENGTH_BITS+4)'(data_byte[3:0]);
    assign status_ovf  = |status_prod[STATUS_BITS+3:STATUS_BITS];
    assign length_ovf  = |length_prod[LENGTH_BITS+3:LENGTH_BITS];

    // Closing a header: a Content-Length header either commits its value or
    // marks the length as bad.
    assign fin_length_value = (cur_in_length && cur_has_digits && !cur_overflow)
                            ? cur_accum : cur_length_value;
    assign fin_bad = cur_length_bad
                   || (cur_in_length && (!cur_has_digits || cur_overflow));

    assign count_inc = cur_count + LENGTH_BITS'(1);

    // Next state and result for one byte.
    always_comb
    begin
        phase_next        = cur_phase;
        status_next       = cur_status;
        accum_next        = cur_accum;
        length_value_next = cur_length_value;
        count_next        = cur_count;
        has_digits_next   = cur_has_digits;
        match_pos_next    = cur_match_pos;
        matches_next      = cur_matches;
        in_length_next    = cur_in_length;
        any_header_next   = cur_any_header;
        stage_next        = cur_stage;
        negative_next     = cur_negative;
        overflow_next     = cur_overflow;
        length_bad_next   = cur_length_bad;
        bad               = 1'b0;
        feed_digits       = 1'b0;
        verdict           = VERDICT_MORE;
        role              = ROLE_FRAME;
        new_hdr           = 1'b0;

        unique case (cur_phase)
            PH_H:
                if (data_byte == CH_H) phase_next = PH_T1; else bad = 1'b1;
            PH_T1:
                if (data_byte == CH_T) phase_next = PH_T2; else bad = 1'b1;
            PH_T2:
                if (data_byte == CH_T) phase_next = PH_P; else bad = 1'b1;
            PH_P:
                if (data_byte == CH_P) phase_next = PH_SLASH; else bad = 1'b1;
            PH_SLASH:
                if (data_byte == CH_SLASH) phase_next = PH_MAJ0; else bad = 1'b1;
            PH_MAJ0:
                if (is_digit(data_byte)) phase_next = PH_MAJ; else bad = 1'b1;
            PH_MAJ:
            begin
                if (data_byte == CH_DOT) phase_next = PH_MIN0;
                else if (!is_digit(data_byte)) bad = 1'b1;
            end
            PH_MIN0:
                if (is_digit(data_byte)) phase_next = PH_MIN; else bad = 1'b1;
            PH_MIN:
            begin
                if (data_byte == CH_SP)
                begin
                    phase_next  = PH_ST0;
                    status_next = '0;
                end
                else if (!is_digit(data_byte))
                begin
                    bad = 1'b1;
                end
            end
            PH_ST0, PH_ST:
            begin
                if (is_digit(data_byte))
                begin
                    status_next = status_ovf ? '1 : status_prod[STATUS_BITS-1:0];
                    phase_next  = PH_ST;
                end
                else if (cur_phase == PH_ST && data_byte == CH_SP)
                begin
                    phase_next = PH_TEXT;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_TEXT:
            begin
                if (data_byte == CH_CR) phase_next = PH_TEXT_LF;
                else if (!is_text(data_byte)) bad = 1'b1;
            end
            PH_TEXT_LF, PH_HDR_LF:
                if (data_byte == CH_LF) phase_next = PH_LINE; else bad = 1'b1;
            PH_LINE:
            begin
                if (data_byte == CH_SP || data_byte == CH_TAB)
                begin
                    if (cur_any_header) phase_next = PH_CONT; else bad = 1'b1;
                end
                else if (is_token(data_byte))
                begin
                    length_value_next = fin_length_value;
                    length_bad_next   = fin_bad;
                    in_length_next    = 1'b0;
                    accum_next        = '0;
                    has_digits_next   = 1'b0;
                    negative_next     = 1'b0;
                    overflow_next     = 1'b0;
                    stage_next        = VS_LEAD;
                    any_header_next   = 1'b1;
                    match_pos_next    = 4'd0;
                    matches_next      = 1'b1;
                    new_hdr           = 1'b1;
                    phase_next        = PH_NAME;
                    role              = ROLE_NAME;
                end
                else if (data_byte == CH_CR)
                begin
                    phase_next = PH_BLANK_LF;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_NAME:
            begin
                if (is_token(data_byte))
                begin
                    role = ROLE_NAME;
                end
                else if (data_byte == CH_COLON)
                begin
                    in_length_next = cur_matches && (cur_match_pos == NAME_LEN);
                    phase_next     = PH_COLON_SP;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_COLON_SP:
                if (data_byte == CH_SP) phase_next = PH_VALUE; else bad = 1'b1;
            PH_CONT, PH_VALUE:
            begin
                // Leading white space of a continuation line is skipped.
                if (!(cur_phase == PH_CONT
                      && (data_byte == CH_SP || data_byte == CH_TAB)))
                begin
                    phase_next = PH_VALUE;
                    if (is_text(data_byte))
                    begin
                        role = ROLE_VALUE;
                        if (cur_in_length)
                        begin
                            unique case (cur_stage)
                                VS_LEAD:
                                begin
                                    if (data_byte == CH_SP)
                                    begin
                                        stage_next = VS_LEAD;
                                    end
                                    else if (data_byte == CH_PLUS
                                             || data_byte == CH_MINUS)
                                    begin
                                        negative_next = (data_byte == CH_MINUS);
                                        stage_next    = VS_DIGITS;
                                    end
                                    else
                                    begin
                                        feed_digits = 1'b1;
                                    end
                                end
                                VS_DIGITS: feed_digits = 1'b1;
                                VS_STOP:   feed_digits = 1'b0;
                                default:   feed_digits = 1'b0;
                            endcase
                            if (feed_digits)
                            begin
                                if (!is_digit(data_byte))
                                begin
                                    stage_next = VS_STOP;
                                end
                                else
                                begin
                                    stage_next      = VS_DIGITS;
                                    has_digits_next = 1'b1;
                                    if (cur_negative)
                                    begin
                                        if (data_byte != CH_ZERO) overflow_next = 1'b1;
                                    end
                                    else if (length_ovf)
                                    begin
                                        overflow_next = 1'b1;
                                    end
                                    else
                                    begin
                                        accum_next = length_prod[LENGTH_BITS-1:0];
                                    end
                                end
                            end
                        end
                    end
                    else if (data_byte == CH_CR)
                    begin
                        phase_next = PH_HDR_LF;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
            end
            PH_BLANK_LF:
            begin
                if (data_byte != CH_LF)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    length_value_next = fin_length_value;
                    length_bad_next   = fin_bad;
                    in_length_next    = 1'b0;
                    accum_next        = '0;
                    has_digits_next   = 1'b0;
                    negative_next     = 1'b0;
                    overflow_next     = 1'b0;
                    stage_next        = VS_LEAD;
                    if (fin_bad)
                    begin
                        bad = 1'b1;
                    end
                    else if (fin_length_value == '0)
                    begin
                        verdict    = VERDICT_DONE;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        count_next = '0;
                        phase_next = PH_CONTENT;
                    end
                end
            end
            PH_CONTENT:
            begin
                role       = ROLE_CONTENT;
                count_next = count_inc;
                if (count_inc >= cur_length_value)
                begin
                    verdict    = VERDICT_DONE;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                verdict    = VERDICT_DONE;
                phase_next = PH_DONE;
            end
            default:
            begin
                verdict    = VERDICT_DONE;
                phase_next = PH_DONE;
            end
        endcase

        // Case-insensitive match of the header name against Content-Length.
        if (role == ROLE_NAME)
        begin
            if (match_pos_next < NAME_LEN)
            begin
                if (to_lower(data_byte) != name_char(match_pos_next))
                    matches_next = 1'b0;
            end
            else
            begin
                matches_next = 1'b0;
            end
            if (match_pos_next < MATCH_POS_MAX)
                match_pos_next = match_pos_next + 4'd1;
        end

        // A malformed byte ends the parse.
        if (bad)
        begin
            verdict    = VERDICT_BAD;
            role       = ROLE_FRAME;
            new_hdr    = 1'b0;
            phase_next = PH_DONE;
        end
    end

    assign result.verdict     = verdict;
    assign result.byte_role   = role;
    assign result.new_header  = new_hdr;
    assign result.echo_byte   = data_byte;
    assign result.status_code = 16'(status_next);
    assign result.body_length = 32'(length_value_next);

    // State update, once per byte handled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_H;
            status_reg       <= '0;
            accum_reg        <= '0;
            length_value_reg <= '0;
            count_reg        <= '0;
            has_digits_reg   <= 1'b0;
            match_pos_reg    <= 4'd0;
            matches_reg      <= 1'b0;
            in_length_reg    <= 1'b0;
            any_header_reg   <= 1'b0;
            stage_reg        <= VS_LEAD;
            negative_reg     <= 1'b0;
            overflow_reg     <= 1'b0;
            length_bad_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            status_reg       <= status_next;
            accum_reg        <= accum_next;
            length_value_reg <= length_value_next;
            count_reg        <= count_next;
            has_digits_reg   <= has_digits_next;
            match_pos_reg    <= match_pos_next;
            matches_reg      <= matches_next;
            in_length_reg    <= in_length_next;
            any_header_reg   <= any_header_next;
            stage_reg        <= stage_next;
            negative_reg     <= negative_next;
            overflow_reg     <= overflow_next;
            length_bad_reg   <= length_bad_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/http_response_byte_parser.sv -----
// HTTP response byte parser: one word in, one result word out per byte.
// A byte taken into the input register is handled once the result register is
// free; its result word is then held there until the result stream takes it.
// Throughput: one byte per cycle while results are taken, one state update per byte.
// Reset: the input and result registers empty, the parser expects "HTTP/".
// Depends on hrbp_pkg, hrbp_channels (interfaces) and hrbp_core.
`timescale 1ns / 1ps
`default_nettype none

module http_response_byte_parser
    import hrbp_pkg::*;
#(
    parameter int LENGTH_BITS = 32,
    parameter int STATUS_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    hrbp_byte_if.sink      stream,
    hrbp_result_if.source  report
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_restart_reg;
    logic         out_valid_reg;
    hrbp_result_t out_reg;
    hrbp_result_t result;
    logic         out_free;
    logic         step;

    // The result register frees up when empty or when its word is taken.
    assign out_free     = !out_valid_reg || report.ready;
    assign step         = in_valid_reg && out_free;
    assign stream.ready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg    <= stream.data_byte;
            in_restart_reg <= stream.restart;
        end
    end

    hrbp_core #(
        .LENGTH_BITS (LENGTH_BITS),
        .STATUS_BITS (STATUS_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .restart   (in_restart_reg),
        .result    (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign report.valid       = out_valid_reg;
    assign report.verdict     = out_reg.verdict;
    assign report.byte_role   = out_reg.byte_role;
    assign report.new_header  = out_reg.new_header;
    assign report.echo_byte   = out_reg.echo_byte;
    assign report.status_code = out_reg.status_code;
    assign report.body_length = out_reg.body_length;

endmodule

`default_nettype wire
